// File: hdl/iobcp_pkg.sv
// ----------------------------------------------------------------------------
// iobcp_pkg
// Types, character codes and the note table shared by the command front end,
// the report queue and the report serializer.
// ----------------------------------------------------------------------------
package iobcp_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_A      = 8'h61;
    localparam logic [7:0] CHAR_G      = 8'h67;

    localparam int NOTE_TABLE_LEN = 25;
    localparam int REPORT_LEN     = 26;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_DATA = 2'd1,
        PH_TERM = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        CMD_REPORT = 3'd0,
        CMD_LAMP   = 3'd1,
        CMD_PIN567 = 3'd2,
        CMD_NOTE   = 3'd3,
        CMD_SET    = 3'd4,
        CMD_CLR    = 3'd5,
        CMD_PWM    = 3'd6
    } cmd_t;

    // one executed command: sensor snapshot plus output state after execution
    typedef struct packed {
        logic [5:0]       din;
        logic [5:0][9:0]  vals;     // a, b, c, sound, d, e at index 0..5
        logic [7:0]       lamp;
        logic [5:0]       pins;
        logic [2:0]       pwm_en;
        logic [2:0][7:0]  duty;     // pins 3, 5, 6 at index 0..2
        logic             tone;
        logic [10:0]      hz;
    } rpt_job_t;

    // pin 3, 5, 6 bits of a pin mask to the matching pwm enable bits
    function automatic logic [2:0] pwm_cancel(input logic [5:0] m);
        return {m[4], m[3], m[1]};
    endfunction

    function automatic logic [10:0] note_hz(input logic [4:0] idx);
        logic [10:0] hz;
        case (idx)
            5'd0:    hz = 11'd262;
            5'd1:    hz = 11'd277;
            5'd2:    hz = 11'd294;
            5'd3:    hz = 11'd311;
            5'd4:    hz = 11'd330;
            5'd5:    hz = 11'd349;
            5'd6:    hz = 11'd370;
            5'd7:    hz = 11'd392;
            5'd8:    hz = 11'd415;
            5'd9:    hz = 11'd440;
            5'd10:   hz = 11'd466;
            5'd11:   hz = 11'd494;
            5'd12:   hz = 11'd523;
            5'd13:   hz = 11'd554;
            5'd14:   hz = 11'd587;
            5'd15:   hz = 11'd622;
            5'd16:   hz = 11'd659;
            5'd17:   hz = 11'd698;
            5'd18:   hz = 11'd740;
            5'd19:   hz = 11'd784;
            5'd20:   hz = 11'd831;
            5'd21:   hz = 11'd880;
            5'd22:   hz = 11'd932;
            5'd23:   hz = 11'd988;
            5'd24:   hz = 11'd1047;
            default: hz = 11'd0;
        endcase
        return hz;
    endfunction

endpackage

// File: hdl/iobcp_front.sv
// ----------------------------------------------------------------------------
// iobcp_front
// Command parser: collects command, data and terminator bytes, updates the
// lamp, pin and pwm state and queues one report job per executed command.
// ----------------------------------------------------------------------------
module iobcp_front
    import iobcp_pkg::*;
#(
    parameter int NOTE_COUNT = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [7:0]  rx_byte,
    input  logic [5:0]  digital_inputs,
    input  logic [9:0]  analog_a,
    input  logic [9:0]  analog_b,
    input  logic [9:0]  analog_c,
    input  logic [9:0]  sound_level,
    input  logic [9:0]  analog_d,
    input  logic [9:0]  analog_e,
    input  logic        q_full,
    output logic        q_push,
    output rpt_job_t    q_job
);

    phase_t          phase_reg, phase_next;
    cmd_t            cmd_reg, cmd_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [1:0][7:0] data_reg;
    logic            data_we;
    logic            data_idx;
    logic [7:0]      lamp_reg, lamp_next;
    logic [5:0]      pin_reg, pin_next;
    logic [2:0]      pwm_on_reg, pwm_on_next;
    logic [2:0][7:0] duty_reg, duty_next;
    logic            accept;
    logic            exec;
    logic            tone;
    logic [10:0]     hz;
    logic [7:0]      d0, d1;

    assign accept = push && !q_full;
    assign d0     = data_reg[0];
    assign d1     = data_reg[1];

    always_comb
    begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        cnt_next    = cnt_reg;
        data_we     = 1'b0;
        data_idx    = cnt_reg[0];
        exec        = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (rx_byte inside {[CHAR_A:CHAR_G]})
                    begin
                        cmd_next   = cmd_t'(3'(rx_byte - CHAR_A));
                        cnt_next   = 2'd0;
                        phase_next = (rx_byte == CHAR_A) ? PH_TERM : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    data_we  = 1'b1;
                    cnt_next = cnt_reg + 2'd1;
                    if (cmd_reg != CMD_PWM || cnt_next >= 2'd2)
                        phase_next = PH_TERM;
                end
                PH_TERM:
                begin
                    phase_next = PH_WAIT;
                    exec       = (rx_byte == CHAR_DOLLAR);
                end
                default:
                    phase_next = PH_WAIT;
            endcase
        end
    end

    // command execution on the terminator
    always_comb
    begin
        lamp_next   = lamp_reg;
        pin_next    = pin_reg;
        pwm_on_next = pwm_on_reg;
        duty_next   = duty_reg;
        tone        = 1'b0;
        hz          = 11'd0;
        case (cmd_reg)
            CMD_LAMP:
                lamp_next = d0;
            CMD_PIN567:
            begin
                pin_next    = {d0[2:0], pin_reg[2:0]};
                pwm_on_next = pwm_on_reg & ~pwm_cancel(6'h38);
            end
            CMD_NOTE:
            begin
                tone = 1'b1;
                if (d0 < 8'(NOTE_COUNT) && d0 < 8'(NOTE_TABLE_LEN))
                    hz = note_hz(d0[4:0]);
            end
            CMD_SET:
            begin
                pin_next    = pin_reg | d0[5:0];
                pwm_on_next = pwm_on_reg & ~pwm_cancel(d0[5:0]);
            end
            CMD_CLR:
            begin
                pin_next    = pin_reg & ~d0[5:0];
                pwm_on_next = pwm_on_reg & ~pwm_cancel(d0[5:0]);
            end
            CMD_PWM:
            begin
                if (d0[0])
                    duty_next[0] = d1;
                if (d0[1])
                    duty_next[1] = d1;
                if (d0[2])
                    duty_next[2] = d1;
                pwm_on_next = pwm_on_reg | d0[2:0];
            end
            default:
            begin
                lamp_next = lamp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            cmd_reg    <= CMD_REPORT;
            cnt_reg    <= 2'd0;
            lamp_reg   <= 8'd0;
            pin_reg    <= 6'd0;
            pwm_on_reg <= 3'd0;
            duty_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            cnt_reg   <= cnt_next;
            if (exec)
            begin
                lamp_reg   <= lamp_next;
                pin_reg    <= pin_next;
                pwm_on_reg <= pwm_on_next;
                duty_reg   <= duty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
            data_reg[data_idx] <= rx_byte;
    end

    assign q_push = exec;

    always_comb
    begin
        q_job.din     = digital_inputs;
        q_job.vals[0] = analog_a;
        q_job.vals[1] = analog_b;
        q_job.vals[2] = analog_c;
        q_job.vals[3] = sound_level;
        q_job.vals[4] = analog_d;
        q_job.vals[5] = analog_e;
        q_job.lamp    = lamp_next;
        q_job.pins    = pin_next;
        q_job.pwm_en  = pwm_on_next;
        q_job.duty    = duty_next;
        q_job.tone    = tone;
        q_job.hz      = hz;
    end

endmodule

// File: hdl/iobcp_queue.sv
// ----------------------------------------------------------------------------
// iobcp_queue
// Short queue of report jobs between the command parser and the serializer.
// ----------------------------------------------------------------------------
module iobcp_queue
    import iobcp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  rpt_job_t wr_job,
    output logic     full,
    input  logic     rd_en,
    output logic     rd_valid,
    output rpt_job_t rd_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rpt_job_t   mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

// File: hdl/iobcp_back.sv
// ----------------------------------------------------------------------------
// iobcp_back
// Report serializer: walks the queued job into the result register, one report
// byte per cycle while the reader pops.
// ----------------------------------------------------------------------------
module iobcp_back
    import iobcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  rpt_job_t    q_job,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  report_byte,
    output logic        last_of_report,
    output logic [7:0]  lamp_bits,
    output logic [5:0]  pin_levels,
    output logic [2:0]  pwm_enable,
    output logic [7:0]  pwm_duty_a,
    output logic [7:0]  pwm_duty_b,
    output logic [7:0]  pwm_duty_c,
    output logic        tone_start,
    output logic [10:0] tone_hz
);

    localparam int IDX_W = $clog2(REPORT_LEN);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic [7:0]       lamp_reg;
    logic [5:0]       pins_reg;
    logic [2:0]       pwm_en_reg;
    logic [2:0][7:0]  duty_reg;
    logic             tone_reg, tone_next;
    logic [10:0]      hz_reg, hz_next;
    logic             load;
    logic [IDX_W-1:0] pos;
    logic [9:0]       word;

    assign load  = q_valid && (!valid_reg || pop);
    assign pos   = idx_reg - IDX_W'(2);
    assign word  = (pos[IDX_W-1:2] < 3'd6) ? q_job.vals[pos[IDX_W-1:2]] : 10'd0;

    always_comb
    begin
        // byte 0 is the marker, byte 1 the input bits, then 4-byte values
        if (idx_reg == '0)
            byte_next = CHAR_HASH;
        else if (idx_reg == IDX_W'(1))
            byte_next = {2'b00, q_job.din};
        else
        begin
            case (pos[1:0])
                2'd2:    byte_next = {6'd0, word[9:8]};
                2'd3:    byte_next = word[7:0];
                default: byte_next = 8'd0;
            endcase
        end
        last_next  = (idx_reg == IDX_W'(REPORT_LEN - 1));
        tone_next  = (idx_reg == '0) && q_job.tone;
        hz_next    = tone_next ? q_job.hz : 11'd0;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = last_next ? '0 : idx_reg + 1'b1;
            valid_next = 1'b1;
        end
        else if (pop)
            valid_next = 1'b0;
    end

    assign q_pop = load && last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= byte_next;
            last_reg   <= last_next;
            lamp_reg   <= q_job.lamp;
            pins_reg   <= q_job.pins;
            pwm_en_reg <= q_job.pwm_en;
            duty_reg   <= q_job.duty;
            tone_reg   <= tone_next;
            hz_reg     <= hz_next;
        end
    end

    assign empty          = !valid_reg;
    assign report_byte    = byte_reg;
    assign last_of_report = last_reg;
    assign lamp_bits      = lamp_reg;
    assign pin_levels     = pins_reg;
    assign pwm_enable     = pwm_en_reg;
    assign pwm_duty_a     = duty_reg[0];
    assign pwm_duty_b     = duty_reg[1];
    assign pwm_duty_c     = duty_reg[2];
    assign tone_start     = tone_reg;
    assign tone_hz        = hz_reg;

endmodule

// File: hdl/io_board_command_protocol.sv
// ----------------------------------------------------------------------------
// io_board_command_protocol
// Command protocol of an I/O board: parses command bytes and emits reports.
// ----------------------------------------------------------------------------
// Received bytes go in through push/full, one transaction per cycle while
// full is low. Command letters a to g, their data bytes and the terminator
// are parsed in the front end; on a '$' terminator the command updates lamp,
// pin and pwm state and a 26-byte sensor report is queued. The serializer
// delivers that report as 26 result transactions, one per cycle while pop
// is high, each carrying the state after the command; a two-report queue
// sits between the parser and the serializer, so input stalls (full high)
// only while both queue slots hold reports, and the byte serializer sets the
// sustained command rate. Bytes that execute nothing queue no report.
module io_board_command_protocol
    import iobcp_pkg::*;
#(
    parameter int NOTE_COUNT = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    input  logic [5:0]  digital_inputs,
    input  logic [9:0]  analog_a,
    input  logic [9:0]  analog_b,
    input  logic [9:0]  analog_c,
    input  logic [9:0]  sound_level,
    input  logic [9:0]  analog_d,
    input  logic [9:0]  analog_e,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  report_byte,
    output logic        last_of_report,
    output logic [7:0]  lamp_bits,
    output logic [5:0]  pin_levels,
    output logic [2:0]  pwm_enable,
    output logic [7:0]  pwm_duty_a,
    output logic [7:0]  pwm_duty_b,
    output logic [7:0]  pwm_duty_c,
    output logic        tone_start,
    output logic [10:0] tone_hz
);

    logic     q_push, q_full, q_pop, q_valid;
    rpt_job_t wr_job, rd_job;

    assign full = q_full;

    iobcp_front #(
        .NOTE_COUNT (NOTE_COUNT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .rx_byte        (rx_byte),
        .digital_inputs (digital_inputs),
        .analog_a       (analog_a),
        .analog_b       (analog_b),
        .analog_c       (analog_c),
        .sound_level    (sound_level),
        .analog_d       (analog_d),
        .analog_e       (analog_e),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_job          (wr_job)
    );

    iobcp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_job   (wr_job),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_job   (rd_job)
    );

    iobcp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_job          (rd_job),
        .q_pop          (q_pop),
        .empty          (empty),
        .pop            (pop),
        .report_byte    (report_byte),
        .last_of_report (last_of_report),
        .lamp_bits      (lamp_bits),
        .pin_levels     (pin_levels),
        .pwm_enable     (pwm_enable),
        .pwm_duty_a     (pwm_duty_a),
        .pwm_duty_b     (pwm_duty_b),
        .pwm_duty_c     (pwm_duty_c),
        .tone_start     (tone_start),
        .tone_hz        (tone_hz)
    );

    // a full queue always has a report under way at the output
    a_full_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue full while no result is presented");

    // a nonzero frequency only rides on the tone strobe
    a_hz_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && tone_hz != 11'd0) |-> tone_start)
        else $error("tone frequency without tone strobe");

    // tone strobe only on the first byte of a report
    a_strobe_on_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && tone_start) |-> (report_byte == CHAR_HASH))
        else $error("tone strobe off the report marker");

    // after the last byte goes, the next result starts a new report
    a_report_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && last_of_report) |=> (empty || report_byte == CHAR_HASH))
        else $error("report does not restart with the marker");

endmodule

// File: sim/iobcp_report_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iobcp_report_checker
// Watches the byte queue and the report queue of the command front end. It
// keeps its own copy of the parser and output state, builds the 26 report
// bytes of every executed command, and compares each popped byte field by
// field with the oldest one due.
// ----------------------------------------------------------------------------
module iobcp_report_checker
    import iobcp_pkg::*;
#(
    parameter int NOTE_COUNT = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  rx_byte,
    input  logic [5:0]  digital_inputs,
    input  logic [9:0]  analog_a,
    input  logic [9:0]  analog_b,
    input  logic [9:0]  analog_c,
    input  logic [9:0]  sound_level,
    input  logic [9:0]  analog_d,
    input  logic [9:0]  analog_e,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  report_byte,
    input  logic        last_of_report,
    input  logic [7:0]  lamp_bits,
    input  logic [5:0]  pin_levels,
    input  logic [2:0]  pwm_enable,
    input  logic [7:0]  pwm_duty_a,
    input  logic [7:0]  pwm_duty_b,
    input  logic [7:0]  pwm_duty_c,
    input  logic        tone_start,
    input  logic [10:0] tone_hz,
    output int          fails,
    output int          pending
);

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [7:0]  lamp;
        logic [5:0]  pins;
        logic [2:0]  pwm_en;
        logic [7:0]  duty_a;
        logic [7:0]  duty_b;
        logic [7:0]  duty_c;
        logic        tone;
        logic [10:0] hz;
    } report_beat_t;

    logic [10:0] note_freq [0:24] = '{
        11'd262, 11'd277, 11'd294, 11'd311, 11'd330, 11'd349, 11'd370, 11'd392,
        11'd415, 11'd440, 11'd466, 11'd494, 11'd523, 11'd554, 11'd587, 11'd622,
        11'd659, 11'd698, 11'd740, 11'd784, 11'd831, 11'd880, 11'd932, 11'd988,
        11'd1047
    };

    report_beat_t beats_due [$];

    phase_t      phase;
    cmd_t        cmd;
    logic [1:0]  data_cnt;
    logic [7:0]  data_reg [2];
    logic [7:0]  lamp;
    logic [5:0]  pins;
    logic [2:0]  pwm_en;
    logic [7:0]  duty [3];

    // snapshot comes from the terminator transaction
    task automatic queue_report(input logic tone, input logic [10:0] hz);
        logic [7:0]   bytes [REPORT_LEN];
        logic [9:0]   vals [6];
        report_beat_t beat;
        vals[0] = analog_a;
        vals[1] = analog_b;
        vals[2] = analog_c;
        vals[3] = sound_level;
        vals[4] = analog_d;
        vals[5] = analog_e;
        bytes[0] = CHAR_HASH;
        bytes[1] = {2'b00, digital_inputs};
        for (int k = 0; k < 6; k++)
        begin
            bytes[2 + 4 * k] = 8'h00;
            bytes[3 + 4 * k] = 8'h00;
            bytes[4 + 4 * k] = {6'b000000, vals[k][9:8]};
            bytes[5 + 4 * k] = vals[k][7:0];
        end
        for (int k = 0; k < REPORT_LEN; k++)
        begin
            beat.data   = bytes[k];
            beat.last   = (k == REPORT_LEN - 1);
            beat.lamp   = lamp;
            beat.pins   = pins;
            beat.pwm_en = pwm_en;
            beat.duty_a = duty[0];
            beat.duty_b = duty[1];
            beat.duty_c = duty[2];
            beat.tone   = (k == 0) && tone;
            beat.hz     = (k == 0 && tone) ? hz : 11'd0;
            beats_due.push_back(beat);
        end
    endtask

    task automatic run_command();
        logic [7:0]  d0;
        logic [7:0]  d1;
        logic [5:0]  m;
        logic        tone;
        logic [10:0] hz;
        d0   = data_reg[0];
        d1   = data_reg[1];
        m    = d0[5:0];
        tone = 1'b0;
        hz   = 11'd0;
        case (cmd)
            CMD_LAMP:
                lamp = d0;
            CMD_PIN567:
            begin
                // pins 5 to 7 are always written, so pwm stops on pins 5 and 6
                pins   = {d0[2:0], pins[2:0]};
                pwm_en = pwm_en & 3'b001;
            end
            CMD_NOTE:
            begin
                tone = 1'b1;
                if (d0 < NOTE_COUNT && d0 < 25)
                    hz = note_freq[d0[4:0]];
            end
            CMD_SET:
            begin
                pins   = pins | m;
                pwm_en = pwm_en & ~{m[4], m[3], m[1]};
            end
            CMD_CLR:
            begin
                pins   = pins & ~m;
                pwm_en = pwm_en & ~{m[4], m[3], m[1]};
            end
            CMD_PWM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (d0[i])
                        duty[i] = d1;
                end
                pwm_en = pwm_en | d0[2:0];
            end
            default:
                ;
        endcase
        queue_report(tone, hz);
    endtask

    task automatic take_byte(input logic [7:0] b);
        logic [7:0] offset;
        offset = b - CHAR_A;
        case (phase)
            PH_WAIT:
            begin
                if (b >= CHAR_A && b <= CHAR_G)
                begin
                    cmd      = cmd_t'(offset[2:0]);
                    data_cnt = 2'd0;
                    phase    = (cmd == CMD_REPORT) ? PH_TERM : PH_DATA;
                end
            end
            PH_DATA:
            begin
                data_reg[data_cnt[0]] = b;
                data_cnt = data_cnt + 2'd1;
                if (cmd != CMD_PWM || data_cnt >= 2'd2)
                    phase = PH_TERM;
            end
            default:
            begin
                // any terminator other than '$' drops the command silently
                phase = PH_WAIT;
                if (b == CHAR_DOLLAR)
                    run_command();
            end
        endcase
    endtask

    task automatic compare(input string name, input logic [10:0] want,
                           input logic [10:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    task automatic check_beat();
        report_beat_t want;
        if (beats_due.size() == 0)
        begin
            $error("report_byte: none expected, got %0d", report_byte);
            fails++;
        end
        else
        begin
            want = beats_due.pop_front();
            compare("report_byte", 11'(want.data), 11'(report_byte));
            compare("last_of_report", 11'(want.last), 11'(last_of_report));
            compare("lamp_bits", 11'(want.lamp), 11'(lamp_bits));
            compare("pin_levels", 11'(want.pins), 11'(pin_levels));
            compare("pwm_enable", 11'(want.pwm_en), 11'(pwm_enable));
            compare("pwm_duty_a", 11'(want.duty_a), 11'(pwm_duty_a));
            compare("pwm_duty_b", 11'(want.duty_b), 11'(pwm_duty_b));
            compare("pwm_duty_c", 11'(want.duty_c), 11'(pwm_duty_c));
            compare("tone_start", 11'(want.tone), 11'(tone_start));
            compare("tone_hz", want.hz, tone_hz);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase       = PH_WAIT;
            cmd         = CMD_REPORT;
            data_cnt    = 2'd0;
            data_reg[0] = 8'h00;
            data_reg[1] = 8'h00;
            lamp        = 8'h00;
            pins        = 6'd0;
            pwm_en      = 3'd0;
            duty[0]     = 8'h00;
            duty[1]     = 8'h00;
            duty[2]     = 8'h00;
            beats_due.delete();
            pending     = 0;
        end
        else
        begin
            if (pop && !empty)
                check_beat();
            if (push && !full)
                take_byte(rx_byte);
            pending = beats_due.size();
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives command byte streams into the I/O board command front end: a short
// directed run over every command but CMD_CLR and the error cases, then random
// command sequences mixed with noise and broken sequences, with random stalls
// on both queues. Reports are checked by iobcp_report_checker.
// ----------------------------------------------------------------------------
module tb;
    import iobcp_pkg::*;

    localparam int NOTE_COUNT   = 25;
    localparam int ITEM_TARGET  = 260;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int DRAIN_CYCLES = 64;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        push           = 1'b0;
    logic        pop            = 1'b0;
    logic [7:0]  rx_byte        = 8'h00;
    logic [5:0]  digital_inputs = 6'd0;
    logic [9:0]  analog_a       = 10'd0;
    logic [9:0]  analog_b       = 10'd0;
    logic [9:0]  analog_c       = 10'd0;
    logic [9:0]  sound_level    = 10'd0;
    logic [9:0]  analog_d       = 10'd0;
    logic [9:0]  analog_e       = 10'd0;

    logic        full;
    logic        empty;
    logic [7:0]  report_byte;
    logic        last_of_report;
    logic [7:0]  lamp_bits;
    logic [5:0]  pin_levels;
    logic [2:0]  pwm_enable;
    logic [7:0]  pwm_duty_a;
    logic [7:0]  pwm_duty_b;
    logic [7:0]  pwm_duty_c;
    logic        tone_start;
    logic [10:0] tone_hz;

    int          fails;
    int          pending;
    int          cycles     = 0;
    int          items_sent = 0;
    int          pop_hold   = 0;
    int          pop_roll;
    int          snap_mode  = 0;    // 0 random, 1 all zero, 2 all ones
    logic        calm       = 1'b0; // no idling on either side

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    io_board_command_protocol #(
        .NOTE_COUNT(NOTE_COUNT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .rx_byte(rx_byte),
        .digital_inputs(digital_inputs),
        .analog_a(analog_a),
        .analog_b(analog_b),
        .analog_c(analog_c),
        .sound_level(sound_level),
        .analog_d(analog_d),
        .analog_e(analog_e),
        .empty(empty),
        .pop(pop),
        .report_byte(report_byte),
        .last_of_report(last_of_report),
        .lamp_bits(lamp_bits),
        .pin_levels(pin_levels),
        .pwm_enable(pwm_enable),
        .pwm_duty_a(pwm_duty_a),
        .pwm_duty_b(pwm_duty_b),
        .pwm_duty_c(pwm_duty_c),
        .tone_start(tone_start),
        .tone_hz(tone_hz)
    );

    iobcp_report_checker #(
        .NOTE_COUNT(NOTE_COUNT)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .rx_byte(rx_byte),
        .digital_inputs(digital_inputs),
        .analog_a(analog_a),
        .analog_b(analog_b),
        .analog_c(analog_c),
        .sound_level(sound_level),
        .analog_d(analog_d),
        .analog_e(analog_e),
        .empty(empty),
        .pop(pop),
        .report_byte(report_byte),
        .last_of_report(last_of_report),
        .lamp_bits(lamp_bits),
        .pin_levels(pin_levels),
        .pwm_enable(pwm_enable),
        .pwm_duty_a(pwm_duty_a),
        .pwm_duty_b(pwm_duty_b),
        .pwm_duty_c(pwm_duty_c),
        .tone_start(tone_start),
        .tone_hz(tone_hz),
        .fails(fails),
        .pending(pending)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // report reader: mostly short stalls, now and then a long one
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (calm)
            pop <= 1'b1;
        else if (pop_hold > 0)
        begin
            pop_hold--;
            pop <= 1'b0;
        end
        else
        begin
            pop_roll = $urandom_range(0, 99);
            if (pop_roll < 70)
                pop <= 1'b1;
            else if (pop_roll < 95)
            begin
                pop_hold = $urandom_range(0, 2);
                pop <= 1'b0;
            end
            else
            begin
                pop_hold = $urandom_range(10, 40);
                pop <= 1'b0;
            end
        end
    end

    function automatic logic [9:0] pick_reading();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 10'd0;
        else if (r == 1)
            return 10'd1023;
        return 10'($urandom_range(0, 1023));
    endfunction

    // one byte transaction; push stays high on return so back-to-back works
    task automatic send(input logic [7:0] b);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        case (snap_mode)
            1:
            begin
                digital_inputs <= 6'd0;
                analog_a       <= 10'd0;
                analog_b       <= 10'd0;
                analog_c       <= 10'd0;
                sound_level    <= 10'd0;
                analog_d       <= 10'd0;
                analog_e       <= 10'd0;
            end
            2:
            begin
                digital_inputs <= 6'h3f;
                analog_a       <= 10'h3ff;
                analog_b       <= 10'h3ff;
                analog_c       <= 10'h3ff;
                sound_level    <= 10'h3ff;
                analog_d       <= 10'h3ff;
                analog_e       <= 10'h3ff;
            end
            default:
            begin
                digital_inputs <= 6'($urandom_range(0, 63));
                analog_a       <= pick_reading();
                analog_b       <= pick_reading();
                analog_c       <= pick_reading();
                sound_level    <= pick_reading();
                analog_d       <= pick_reading();
                analog_e       <= pick_reading();
            end
        endcase
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic send_command(input cmd_t c, input logic [7:0] d0,
                                input logic [7:0] d1, input logic [7:0] term);
        send(CHAR_A + 8'(c));
        items_sent++;
        if (c != CMD_REPORT)
        begin
            send(d0);
            items_sent++;
        end
        if (c == CMD_PWM)
        begin
            send(d1);
            items_sent++;
        end
        send(term);
        items_sent++;
    endtask

    // hold the sender until every report due has been read
    task automatic wait_reports_out();
        push <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        cmd_t       c;
        int         r;
        int         next_switch;
        logic [7:0] d0;
        logic [7:0] term;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        snap_mode = 1;
        send_command(CMD_REPORT, 8'h00, 8'h00, CHAR_DOLLAR);
        send(8'hff);                                    // not a command letter
        snap_mode = 2;
        send_command(CMD_LAMP, 8'hff, 8'h00, CHAR_DOLLAR);
        snap_mode = 0;
        send_command(CMD_PWM, 8'h07, 8'hff, CHAR_DOLLAR);
        send_command(CMD_SET, 8'h3f, 8'h00, CHAR_DOLLAR);
        send_command(CMD_PIN567, 8'h05, 8'h00, CHAR_DOLLAR);
        send_command(CMD_NOTE, 8'd24, 8'h00, CHAR_DOLLAR);
        send_command(CMD_NOTE, 8'd25, 8'h00, CHAR_DOLLAR);
        // '$' taken as data, then a bad terminator
        send_command(CMD_LAMP, CHAR_DOLLAR, 8'h00, CHAR_HASH);
        send_command(CMD_REPORT, 8'h00, 8'h00, CHAR_DOLLAR);
        wait_reports_out();

        // random part
        next_switch = items_sent;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= next_switch)
            begin
                calm <= ($urandom_range(0, 3) == 0);
                next_switch = items_sent + 30;
            end
            if ($urandom_range(0, 19) == 0)
                wait_reports_out();
            r  = $urandom_range(0, 99);
            c  = cmd_t'($urandom_range(0, 6));
            d0 = 8'($urandom_range(0, 255));
            if (c == CMD_NOTE && $urandom_range(0, 4) != 0)
                d0 = 8'($urandom_range(0, 30));
            if (r < 8)
                send(8'($urandom_range(0, 255)));
            else if (r < 16)
            begin
                term = 8'($urandom_range(0, 255));
                while (term == CHAR_DOLLAR)
                    term = 8'($urandom_range(0, 255));
                send_command(c, d0, 8'($urandom_range(0, 255)), term);
            end
            else
                send_command(c, d0, 8'($urandom_range(0, 255)), CHAR_DOLLAR);
        end

        calm <= 1'b0;
        wait_reports_out();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fails == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// File: io_board_command_protocol.f
hdl/iobcp_pkg.sv
hdl/iobcp_front.sv
hdl/iobcp_queue.sv
hdl/iobcp_back.sv
hdl/io_board_command_protocol.sv
sim/iobcp_report_checker.sv
sim/tb.sv
